// ----- hdl/mssc_pkg.sv -----
// Shared types and constants of the MIPS-subset core.
// Used by every module of the core and by its port checker; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package mssc_pkg;

	localparam int DMEM_BYTES_DEF = 65536;
	localparam int NUM_REGS       = 32;

	localparam logic [31:0] HALT_INSTR = 32'hffff_ffff;

	// Primary opcodes, instruction bits [31:26].
	localparam logic [5:0] OPC_RTYPE = 6'h00;
	localparam logic [5:0] OPC_J     = 6'h02;
	localparam logic [5:0] OPC_BEQ   = 6'h04;
	localparam logic [5:0] OPC_ADDIU = 6'h09;
	localparam logic [5:0] OPC_LW    = 6'h23;
	localparam logic [5:0] OPC_SW    = 6'h2b;

	// R-type function, low three bits of funct.
	localparam logic [2:0] FN_ADDU = 3'd1;
	localparam logic [2:0] FN_SUBU = 3'd3;
	localparam logic [2:0] FN_AND  = 3'd4;
	localparam logic [2:0] FN_OR   = 3'd5;
	localparam logic [2:0] FN_NOR  = 3'd7;

	typedef enum logic [1:0] {
		ITEM_EXEC   = 2'd0,
		ITEM_WRBYTE = 2'd1,
		ITEM_RDBYTE = 2'd2,
		ITEM_RDREG  = 2'd3
	} item_op_t;

	// Input beat, first field in the highest bits.
	typedef struct packed {
		logic [2:0]  pad;
		logic [4:0]  reg_select;
		logic [7:0]  mem_byte;
		logic [15:0] mem_addr;
		logic [31:0] instruction;
	} in_beat_t;

	// Result beat, first field in the highest bits.
	typedef struct packed {
		logic        mem_written;
		logic [31:0] written_value;
		logic [4:0]  written_reg;
		logic        reg_written;
		logic [31:0] read_value;
		logic        halted;
		logic [31:0] next_pc;
	} out_beat_t;

	typedef struct packed {
		logic        en;
		logic [4:0]  addr;
		logic [31:0] data;
	} rf_wr_t;

	// Data memory request; addr is a byte address, wrapped by the memory.
	typedef struct packed {
		logic        rd_en;
		logic        wr_en;
		logic        word;
		logic [31:0] addr;
		logic [31:0] wdata;
	} dmem_req_t;

endpackage

`default_nettype wire

// ----- hdl/mips_subset_single_cycle_core.sv -----
// MIPS-subset core: one instruction per execute beat, plus memory/register access beats.
//
// Input channel s_*: s_tuser carries the beat kind (execute, write memory byte,
// read memory byte, read register); s_tdata carries the instruction word fetched
// at the current PC, a memory byte address, a byte to store and a register number.
// Output channel m_*: one result beat per input beat, in order: the next PC, the
// sticky halt flag, a read value and what the instruction wrote.
// Pipeline: the register file is read on the accept edge, stage 1 executes and
// writes the register file or data memory and updates the PC, stage 2 collects
// load data from the data memory's registered read port, then an output register
// holds the result. Throughput is one beat per cycle while m_tready is high, except
// that a lw that writes a register holds the next beat in stage 1 until the loaded
// word is in the register file. Register operands are forwarded from the write made
// on the edge of their read.
// Reset clears the PC, the halt flag and all registers; data memory content is
// undefined until written. When m_tready is low the result holds in the output
// register, stage 2 fills behind it and s_tready falls once stage 1 is blocked.
`timescale 1ns / 1ps
`default_nettype none

module mips_subset_single_cycle_core #(
	parameter int DMEM_BYTES = mssc_pkg::DMEM_BYTES_DEF
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// instruction[31:0], mem_addr[47:32], mem_byte[55:48], reg_select[60:56], zero pad
	input  wire logic [63:0]  s_tdata,
	// op[1:0]
	input  wire logic [1:0]   s_tuser,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// next_pc[31:0], halted[32], read_value[64:33], reg_written[65], written_reg[70:66],
	// written_value[102:71], mem_written[103]
	output logic [103:0]      m_tdata
);

	mssc_pkg::in_beat_t  in_beat;
	mssc_pkg::item_op_t  in_op;

	// Stage 1.
	logic                s1_valid_q;
	mssc_pkg::item_op_t  op_s1;
	mssc_pkg::in_beat_t  beat_s1;
	logic                s1_adv;
	logic                s1_fire;

	// Stage 2.
	logic                s2_valid_q;
	mssc_pkg::out_beat_t res_s2;
	logic                ld_s2;
	logic                rdb_s2;
	logic                s2_free;
	logic                s2_fire;
	mssc_pkg::out_beat_t fin_s2;

	// Output register.
	logic                out_valid_q;
	mssc_pkg::out_beat_t out_q;

	logic [31:0] pc_q;
	logic        halt_q;

	logic [4:0]  raddr_a;
	logic [4:0]  raddr_b;
	logic [31:0] op_a;
	logic [31:0] op_b;
	logic [31:0] dmem_rdata;
	mssc_pkg::rf_wr_t  rf_wr;
	mssc_pkg::dmem_req_t dreq;

	// Stage 1 results.
	mssc_pkg::out_beat_t res_s1;
	logic        ld_s1;
	logic        set_halt;
	logic        run;
	logic [31:0] npc;
	logic        rf_we_s1;
	logic [4:0]  rf_dst_s1;
	logic [31:0] rf_val_s1;

	logic [5:0]  opc;
	logic [4:0]  rt;
	logic [4:0]  rd;
	logic [31:0] sext;
	logic [31:0] pc4;
	logic [31:0] ea;
	logic [31:0] alu;

	assign in_beat = mssc_pkg::in_beat_t'(s_tdata);
	assign in_op   = mssc_pkg::item_op_t'(s_tuser);

	// Handshake and stage movement.
	assign s2_free  = !s2_valid_q || (!out_valid_q || m_tready);
	assign s2_fire  = s2_valid_q && (!out_valid_q || m_tready);
	assign s1_adv   = s1_valid_q && s2_free && !(s2_valid_q && ld_s2);
	assign s1_fire  = s1_adv;
	assign s_tready = !s1_valid_q || s1_adv;

	// Register reads follow the waiting stage 1 beat, else the incoming one.
	always_comb begin
		if (s1_valid_q && !s1_adv) begin
			raddr_a = (op_s1 == mssc_pkg::ITEM_RDREG) ? beat_s1.reg_select
			                                          : beat_s1.instruction[25:21];
			raddr_b = beat_s1.instruction[20:16];
		end else begin
			raddr_a = (in_op == mssc_pkg::ITEM_RDREG) ? in_beat.reg_select
			                                          : in_beat.instruction[25:21];
			raddr_b = in_beat.instruction[20:16];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			op_s1      <= mssc_pkg::ITEM_EXEC;
		end else if (s_tready) begin
			s1_valid_q <= s_tvalid;
			if (s_tvalid) begin
				op_s1 <= in_op;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			beat_s1 <= in_beat;
		end
	end

	// Execute.
	always_comb begin
		opc  = beat_s1.instruction[31:26];
		rt   = beat_s1.instruction[20:16];
		rd   = beat_s1.instruction[15:11];
		sext = {{16{beat_s1.instruction[15]}}, beat_s1.instruction[15:0]};
		pc4  = pc_q + 32'd4;
		ea   = op_a + sext;

		case (beat_s1.instruction[2:0])
			mssc_pkg::FN_ADDU: alu = op_a + op_b;
			mssc_pkg::FN_SUBU: alu = op_a - op_b;
			mssc_pkg::FN_AND:  alu = op_a & op_b;
			mssc_pkg::FN_OR:   alu = op_a | op_b;
			mssc_pkg::FN_NOR:  alu = ~(op_a | op_b);
			default:           alu = '0;
		endcase

		set_halt = (op_s1 == mssc_pkg::ITEM_EXEC) && !halt_q &&
		           (beat_s1.instruction == mssc_pkg::HALT_INSTR ||
		            pc_q > 32'(DMEM_BYTES));
		run      = (op_s1 == mssc_pkg::ITEM_EXEC) && !halt_q && !set_halt;

		npc       = pc_q;
		rf_we_s1  = 1'b0;
		rf_dst_s1 = rt;
		rf_val_s1 = '0;
		ld_s1     = 1'b0;
		dreq      = '0;
		res_s1    = '0;

		if (run) begin
			npc = pc4;
			case (opc)
				mssc_pkg::OPC_RTYPE: begin
					rf_we_s1  = 1'b1;
					rf_dst_s1 = rd;
					rf_val_s1 = alu;
				end
				mssc_pkg::OPC_ADDIU: begin
					rf_we_s1  = 1'b1;
					rf_val_s1 = ea;
				end
				mssc_pkg::OPC_LW: begin
					ld_s1 = (rt != 5'd0);
				end
				mssc_pkg::OPC_SW: begin
					dreq.wr_en       = 1'b1;
					dreq.word        = 1'b1;
					dreq.addr        = ea;
					dreq.wdata       = op_b;
					res_s1.mem_written = 1'b1;
				end
				mssc_pkg::OPC_BEQ: begin
					if (op_a == op_b) begin
						npc = pc4 + {sext[29:0], 2'b00};
					end
				end
				mssc_pkg::OPC_J: begin
					npc = {pc4[31:28], beat_s1.instruction[25:0], 2'b00};
				end
				default: begin
					npc = pc4;
				end
			endcase
			if (ld_s1) begin
				dreq.rd_en = 1'b1;
				dreq.word  = 1'b1;
				dreq.addr  = ea;
			end
		end

		case (op_s1)
			mssc_pkg::ITEM_WRBYTE: begin
				dreq.wr_en = 1'b1;
				dreq.addr  = {16'd0, beat_s1.mem_addr};
				dreq.wdata = {24'd0, beat_s1.mem_byte};
			end
			mssc_pkg::ITEM_RDBYTE: begin
				dreq.rd_en = 1'b1;
				dreq.addr  = {16'd0, beat_s1.mem_addr};
			end
			mssc_pkg::ITEM_RDREG: begin
				res_s1.read_value = op_a;
			end
			default: begin
				res_s1.read_value = '0;
			end
		endcase

		// Register zero is never written.
		rf_we_s1 = rf_we_s1 && (rf_dst_s1 != 5'd0);
		if (rf_we_s1 || ld_s1) begin
			res_s1.reg_written   = 1'b1;
			res_s1.written_reg   = rf_dst_s1;
			res_s1.written_value = rf_val_s1;
		end
		res_s1.next_pc = npc;
		res_s1.halted  = halt_q || set_halt;

		// Side effects only take place when the beat leaves stage 1.
		dreq.rd_en = dreq.rd_en && s1_fire;
		dreq.wr_en = dreq.wr_en && s1_fire;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q   <= '0;
			halt_q <= 1'b0;
		end else if (s1_fire) begin
			pc_q   <= res_s1.next_pc;
			halt_q <= res_s1.halted;
		end
	end

	// Single write port: a stage 1 write and a load write never meet, by the interlock.
	always_comb begin
		if (s2_fire && ld_s2) begin
			rf_wr.en   = 1'b1;
			rf_wr.addr = res_s2.written_reg;
			rf_wr.data = dmem_rdata;
		end else begin
			rf_wr.en   = s1_fire && rf_we_s1;
			rf_wr.addr = rf_dst_s1;
			rf_wr.data = rf_val_s1;
		end
	end

	mssc_regfile u_regfile (
		.clk     (clk),
		.arst_n  (arst_n),
		.raddr_a (raddr_a),
		.raddr_b (raddr_b),
		.wr      (rf_wr),
		.rdata_a (op_a),
		.rdata_b (op_b)
	);

	mssc_dmem #(
		.DMEM_BYTES (DMEM_BYTES)
	) u_dmem (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dreq),
		.rdata  (dmem_rdata)
	);

	// Stage 2.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_valid_q <= 1'b0;
			ld_s2      <= 1'b0;
			rdb_s2     <= 1'b0;
		end else if (s2_free) begin
			s2_valid_q <= s1_fire;
			ld_s2      <= s1_fire && ld_s1;
			rdb_s2     <= s1_fire && (op_s1 == mssc_pkg::ITEM_RDBYTE);
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire) begin
			res_s2 <= res_s1;
		end
	end

	always_comb begin
		fin_s2 = res_s2;
		if (ld_s2) begin
			fin_s2.written_value = dmem_rdata;
		end
		if (rdb_s2) begin
			fin_s2.read_value = dmem_rdata;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || m_tready) begin
			out_valid_q <= s2_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_fire) begin
			out_q <= fin_s2;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q;

endmodule

`default_nettype wire

// ----- hdl/mssc_regfile.sv -----
// Register file: 32 x 32 synchronous memory, two read ports, one write port.
// Reset-cleared valid bits make unwritten registers read zero. Uses mssc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mssc_regfile (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic [4:0]       raddr_a,
	input  wire logic [4:0]       raddr_b,
	input  wire mssc_pkg::rf_wr_t wr,
	output logic [31:0]           rdata_a,
	output logic [31:0]           rdata_b
);

	logic [31:0] mem [mssc_pkg::NUM_REGS];
	logic [mssc_pkg::NUM_REGS-1:0] vld_q;
	logic [31:0] mem_a_q;
	logic [31:0] mem_b_q;
	logic [4:0]  raddr_a_q;
	logic [4:0]  raddr_b_q;
	mssc_pkg::rf_wr_t fwd_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		mem_a_q <= mem[raddr_a];
		mem_b_q <= mem[raddr_b];
	end

	// The write that lands on the same edge as a read is not seen by that read,
	// so it is registered for forwarding.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			raddr_a_q <= '0;
			raddr_b_q <= '0;
			fwd_q     <= '0;
		end else begin
			if (wr.en) begin
				vld_q[wr.addr] <= 1'b1;
			end
			raddr_a_q <= raddr_a;
			raddr_b_q <= raddr_b;
			fwd_q     <= wr;
		end
	end

	always_comb begin
		if (fwd_q.en && fwd_q.addr == raddr_a_q) begin
			rdata_a = fwd_q.data;
		end else if (vld_q[raddr_a_q]) begin
			rdata_a = mem_a_q;
		end else begin
			rdata_a = '0;
		end
		if (fwd_q.en && fwd_q.addr == raddr_b_q) begin
			rdata_b = fwd_q.data;
		end else if (vld_q[raddr_b_q]) begin
			rdata_b = mem_b_q;
		end else begin
			rdata_b = '0;
		end
	end

endmodule

`default_nettype wire

// ----- hdl/mssc_dmem.sv -----
// Byte-addressed big-endian data memory, four byte-wide banks of synchronous RAM.
// Serves byte and word accesses, each byte address wrapping on its own. Uses mssc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mssc_dmem #(
	parameter int DMEM_BYTES = mssc_pkg::DMEM_BYTES_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire mssc_pkg::dmem_req_t req,
	output logic [31:0]              rdata
);

	// DMEM_BYTES must be a power of two (the block does not check it), so wrapping keeps the low address bits.
	localparam int AW   = $clog2(DMEM_BYTES);
	localparam int RW   = AW - 2;
	localparam int ROWS = DMEM_BYTES / 4;

	logic [1:0]    lo;
	logic [RW-1:0] base_row;
	logic [1:0]    lo_q;
	logic          word_q;
	wire  [7:0]    bank_rd [4];

	assign lo       = req.addr[1:0];
	assign base_row = req.addr[AW-1:2];

	for (genvar k = 0; k < 4; k++) begin : g_bank
		logic [7:0]    ram [ROWS];
		logic [7:0]    rd_q;
		logic [1:0]    lane;
		logic [RW-1:0] row;
		logic          wen;
		logic [31:0]   shifted;
		logic [7:0]    wbyte;

		// Lane is the byte's place in the word; banks below the start wrap a row up.
		assign lane    = 2'(k) - lo;
		assign row     = base_row + RW'(req.word && (2'(k) < lo));
		assign wen     = req.wr_en && (req.word || 2'(k) == lo);
		assign shifted = req.wdata >> {2'(2'd3 - lane), 3'b000};
		assign wbyte   = req.word ? shifted[7:0] : req.wdata[7:0];

		always_ff @(posedge clk) begin
			if (wen) begin
				ram[row] <= wbyte;
			end
			if (req.rd_en) begin
				rd_q <= ram[row];
			end
		end

		assign bank_rd[k] = rd_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lo_q   <= '0;
			word_q <= 1'b0;
		end else if (req.rd_en) begin
			lo_q   <= lo;
			word_q <= req.word;
		end
	end

	always_comb begin
		rdata = '0;
		if (word_q) begin
			for (int i = 0; i < 4; i++) begin
				rdata[31-8*i -: 8] = bank_rd[2'(lo_q + 2'(i))];
			end
		end else begin
			rdata = {24'd0, bank_rd[lo_q]};
		end
	end

endmodule

`default_nettype wire

// ----- hdl/mssc_checker.sv -----
// Port checker for the MIPS-subset core, bound to the top level.
// Watches the result channel only; uses mssc_pkg for the result beat layout.
`timescale 1ns / 1ps
`default_nettype none

module mssc_checker (
	input wire logic         clk,
	input wire logic         arst_n,
	input wire logic         m_tvalid,
	input wire logic         m_tready,
	input wire logic [103:0] m_tdata
);

	mssc_pkg::out_beat_t beat;
	logic                seen_halt_q;

	assign beat = mssc_pkg::out_beat_t'(m_tdata);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_halt_q <= 1'b0;
		end else if (m_tvalid && m_tready && beat.halted) begin
			seen_halt_q <= 1'b1;
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result beat changed while stalled");

	// Once a halted beat has left, every later beat reports halt.
	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && seen_halt_q |-> beat.halted)
		else $error("halt flag dropped");

	a_no_write_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !beat.reg_written |-> beat.written_reg == 5'd0 &&
		beat.written_value == 32'd0)
		else $error("write fields set without a register write");

	a_write_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && beat.reg_written |-> beat.written_reg != 5'd0 && !beat.mem_written)
		else $error("register write to r0 or together with a store");

endmodule

bind mips_subset_single_cycle_core mssc_checker u_mssc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

`default_nettype wire
